/* rtl/int_calc_decimal_out_defines.svh */
// ----------------------------------------------------------------------------
// Integer calculator assertion macros
// Shared property macros for the checker of the decimal text calculator.
// ----------------------------------------------------------------------------
`ifndef INT_CALC_DECIMAL_OUT_DEFINES_SVH
`define INT_CALC_DECIMAL_OUT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ICD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("icd checker: same-cycle property failed");

// next-cycle implication, disabled during reset
`define ICD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("icd checker: next-cycle property failed");

`endif

/* rtl/icd_pkg.sv */
// ----------------------------------------------------------------------------
// icd_pkg
// Types, constants and helpers of the integer calculator with decimal output.
// ----------------------------------------------------------------------------
package icd_pkg;

    localparam int ICD_WIDTH       = 32;
    localparam int ICD_DIGITS      = 10;
    localparam int ICD_BCD_W       = 4 * ICD_DIGITS;
    localparam int ICD_DIG_IDX_W   = $clog2(ICD_DIGITS);
    localparam int ICD_QUEUE_DEPTH = 16;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_MOD  = 3'd4;
    localparam logic [2:0] OP_NONE = 3'd5;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic signed [ICD_WIDTH-1:0] operand_a;
        logic signed [ICD_WIDTH-1:0] operand_b;
        logic [2:0]                  operation;
    } t_calc_in;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_char;
    } t_calc_out;

    // one slot of the divider chain
    typedef struct packed {
        logic                 valid;
        logic                 have;
        logic                 is_div;
        logic                 sel_quo;
        logic                 neg_quo;
        logic                 neg_rem;
        logic [ICD_WIDTH-1:0] value;
        logic [ICD_WIDTH-1:0] rem;
        logic [ICD_WIDTH-1:0] quo;
        logic [ICD_WIDTH-1:0] dvs;
    } t_div_lane;

    // one slot of the binary to BCD chain
    typedef struct packed {
        logic                 valid;
        logic                 have;
        logic                 neg;
        logic [ICD_WIDTH-1:0] bin;
        logic [ICD_BCD_W-1:0] bcd;
    } t_dd_lane;

    typedef struct packed {
        logic                 have;
        logic                 neg;
        logic [ICD_BCD_W-1:0] bcd;
    } t_q_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT,
        ST_NEWLINE
    } t_ser_state;

    // index of the most significant nonzero digit, zero for an all-zero value
    function automatic logic [ICD_DIG_IDX_W-1:0] lead_index(input logic [ICD_BCD_W-1:0] bcd);
        logic [ICD_DIG_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < ICD_DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                idx = ICD_DIG_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/int_calc_decimal_out.sv */
// ----------------------------------------------------------------------------
// int_calc_decimal_out
// 32-bit add/sub/mul/div/mod calculator printing its answer as decimal ASCII.
// ----------------------------------------------------------------------------
//  channel  | ports                    | handshake
//  ---------+--------------------------+-----------------------------------
//  command  | start, busy, i_data      | taken when start high, busy low
//  result   | o_strobe, o_data         | one char per strobe, no stall
//
// A transaction emits 1 to 12 characters on consecutive cycles, one per
// cycle from the output sequencer, which sets the sustained rate. Results
// pass through a 32-cell divider chain and a 32-cell BCD chain.
// Up to QUEUE_DEPTH transactions are in flight; busy rises when all are taken.
// Reset is synchronous and clears all valid flags, counters and the sequencer.
// ----------------------------------------------------------------------------
module int_calc_decimal_out import icd_pkg::*; #(
    parameter int QUEUE_DEPTH = ICD_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_calc_in  i_data,
    output logic      o_strobe,
    output t_calc_out o_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                 w_accept;
    logic                 w_pop;
    logic [CNT_W-1:0]     r_inflight;
    logic                 r_in_vld;
    t_calc_in             r_in;
    t_div_lane            r_div_in;
    t_div_lane            n_div_in;
    t_div_lane            w_div [ICD_WIDTH+1];
    logic                 r_res_vld;
    logic                 r_res_have;
    logic [ICD_WIDTH-1:0] r_res;
    logic [ICD_WIDTH-1:0] n_res;
    t_dd_lane             r_dd_in;
    t_dd_lane             w_dd [ICD_WIDTH+1];
    logic [ICD_WIDTH-1:0] w_a;
    logic [ICD_WIDTH-1:0] w_b;

    assign busy     = (r_inflight == CNT_W'(QUEUE_DEPTH));
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(w_accept) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_data;
        end
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_accept;
        end
    end

    // operand prep: add, subtract, low product, magnitudes for the divider
    assign w_a = r_in.operand_a;
    assign w_b = r_in.operand_b;

    always_comb begin
        n_div_in.valid   = r_in_vld;
        n_div_in.is_div  = (r_in.operation == OP_DIV) || (r_in.operation == OP_MOD);
        n_div_in.have    = (r_in.operation inside {OP_ADD, OP_SUB, OP_MUL}) ||
                           (n_div_in.is_div && (w_b != '0));
        n_div_in.sel_quo = (r_in.operation == OP_DIV);
        n_div_in.neg_quo = w_a[ICD_WIDTH-1] ^ w_b[ICD_WIDTH-1];
        n_div_in.neg_rem = w_a[ICD_WIDTH-1];
        case (r_in.operation)
            OP_ADD:  n_div_in.value = w_a + w_b;
            OP_SUB:  n_div_in.value = w_a - w_b;
            default: n_div_in.value = ICD_WIDTH'(w_a * w_b);
        endcase
        n_div_in.rem = '0;
        n_div_in.quo = w_a[ICD_WIDTH-1] ? -w_a : w_a;
        n_div_in.dvs = w_b[ICD_WIDTH-1] ? -w_b : w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_in <= '0;
        end else begin
            r_div_in <= n_div_in;
        end
    end

    assign w_div[0] = r_div_in;

    for (genvar g = 0; g < ICD_WIDTH; g++) begin : g_div
        icd_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_lane (w_div[g]),
            .o_lane (w_div[g+1])
        );
    end

    // pass the arithmetic result, or apply signs to quotient or remainder
    always_comb begin
        if (!w_div[ICD_WIDTH].is_div) begin
            n_res = w_div[ICD_WIDTH].value;
        end else if (w_div[ICD_WIDTH].sel_quo) begin
            n_res = w_div[ICD_WIDTH].neg_quo ? -w_div[ICD_WIDTH].quo : w_div[ICD_WIDTH].quo;
        end else begin
            n_res = w_div[ICD_WIDTH].neg_rem ? -w_div[ICD_WIDTH].rem : w_div[ICD_WIDTH].rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_res_have <= w_div[ICD_WIDTH].have;
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= w_div[ICD_WIDTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dd_in.have <= r_res_have;
        r_dd_in.neg  <= r_res_have && r_res[ICD_WIDTH-1];
        r_dd_in.bin  <= r_res[ICD_WIDTH-1] ? -r_res : r_res;
        r_dd_in.bcd  <= '0;
        if (!i_rst_n) begin
            r_dd_in.valid <= 1'b0;
        end else begin
            r_dd_in.valid <= r_res_vld;
        end
    end

    assign w_dd[0] = r_dd_in;

    for (genvar g = 0; g < ICD_WIDTH; g++) begin : g_dd
        icd_dd_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_lane (w_dd[g]),
            .o_lane (w_dd[g+1])
        );
    end

    icd_serializer #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lane  (w_dd[ICD_WIDTH]),
        .o_pop   (w_pop),
        .o_strobe(o_strobe),
        .o_data  (o_data)
    );

endmodule

/* rtl/icd_div_cell.sv */
// ----------------------------------------------------------------------------
// icd_div_cell
// One restoring division step; passes its slot to the next cell every cycle.
// ----------------------------------------------------------------------------
module icd_div_cell import icd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    t_div_lane            r_lane;
    t_div_lane            n_lane;
    logic [ICD_WIDTH+1:0] w_trial;

    always_comb begin
        n_lane  = i_lane;
        w_trial = {1'b0, i_lane.rem, i_lane.quo[ICD_WIDTH-1]} - {2'b00, i_lane.dvs};
        if (!w_trial[ICD_WIDTH+1]) begin
            n_lane.rem = w_trial[ICD_WIDTH-1:0];
            n_lane.quo = {i_lane.quo[ICD_WIDTH-2:0], 1'b1};
        end else begin
            n_lane.rem = {i_lane.rem[ICD_WIDTH-2:0], i_lane.quo[ICD_WIDTH-1]};
            n_lane.quo = {i_lane.quo[ICD_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

/* rtl/icd_dd_cell.sv */
// ----------------------------------------------------------------------------
// icd_dd_cell
// One shift-and-add-3 step of binary to BCD conversion.
// ----------------------------------------------------------------------------
module icd_dd_cell import icd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dd_lane i_lane,
    output t_dd_lane o_lane
);

    t_dd_lane             r_lane;
    t_dd_lane             n_lane;
    logic [ICD_BCD_W-1:0] w_adj;

    always_comb begin
        for (int i = 0; i < ICD_DIGITS; i++) begin
            w_adj[i*4 +: 4] = (i_lane.bcd[i*4 +: 4] >= 4'd5) ?
                              i_lane.bcd[i*4 +: 4] + 4'd3 : i_lane.bcd[i*4 +: 4];
        end
        n_lane     = i_lane;
        n_lane.bcd = {w_adj[ICD_BCD_W-2:0], i_lane.bin[ICD_WIDTH-1]};
        n_lane.bin = {i_lane.bin[ICD_WIDTH-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

/* rtl/icd_serializer.sv */
// ----------------------------------------------------------------------------
// icd_serializer
// Queues converted results and emits them one ASCII character per cycle.
// ----------------------------------------------------------------------------
module icd_serializer import icd_pkg::*; #(
    parameter int QUEUE_DEPTH = ICD_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dd_lane  i_lane,
    output logic      o_pop,
    output logic      o_strobe,
    output t_calc_out o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_q_entry                 r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]         r_wr;
    logic [PTR_W-1:0]         r_rd;
    logic [CNT_W-1:0]         r_fill;
    t_ser_state               r_state;
    t_ser_state               n_state;
    logic [ICD_BCD_W-1:0]     r_bcd;
    logic [ICD_DIG_IDX_W-1:0] r_idx;
    t_q_entry                 w_head;
    logic                     w_load;
    logic [3:0]               w_digit;

    assign w_head  = r_mem[r_rd];
    assign w_load  = (r_fill != '0) && ((r_state == ST_IDLE) || (r_state == ST_NEWLINE));
    assign o_pop   = w_load;
    assign w_digit = r_bcd[r_idx*4 +: 4];

    always_ff @(posedge i_clk) begin
        if (i_lane.valid) begin
            r_mem[r_wr] <= '{have: i_lane.have, neg: i_lane.neg, bcd: i_lane.bcd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_lane.valid) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_load) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_fill <= r_fill + CNT_W'(i_lane.valid) - CNT_W'(w_load);
        end
    end

    // next state
    always_comb begin
        case (r_state)
            ST_IDLE, ST_NEWLINE: begin
                if (w_load) begin
                    n_state = !w_head.have ? ST_NEWLINE : (w_head.neg ? ST_SIGN : ST_DIGIT);
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SIGN:  n_state = ST_DIGIT;
            ST_DIGIT: n_state = (r_idx == '0) ? ST_NEWLINE : ST_DIGIT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bcd <= w_head.bcd;
            r_idx <= lead_index(w_head.bcd);
        end else if ((r_state == ST_DIGIT) && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // outputs
    always_comb begin
        o_strobe         = 1'b1;
        o_data.last_char = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_strobe       = 1'b0;
                o_data.char_out = CH_NEWLINE;
            end
            ST_SIGN:  o_data.char_out = CH_MINUS;
            ST_DIGIT: o_data.char_out = CH_ZERO + {4'd0, w_digit};
            ST_NEWLINE: begin
                o_data.char_out  = CH_NEWLINE;
                o_data.last_char = 1'b1;
            end
            default: begin
                o_strobe       = 1'b0;
                o_data.char_out = CH_NEWLINE;
            end
        endcase
    end

endmodule

/* rtl/icd_checker.sv */
// ----------------------------------------------------------------------------
// icd_checker
// Port-level checks on the character stream of the calculator.
// ----------------------------------------------------------------------------
`include "int_calc_decimal_out_defines.svh"

module icd_checker import icd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_strobe,
    input t_calc_out o_data
);

    `ICD_ASSERT_IMPLY(a_last_is_newline, i_clk, i_rst_n, o_strobe && o_data.last_char, o_data.char_out == CH_NEWLINE)
    `ICD_ASSERT_IMPLY(a_body_char, i_clk, i_rst_n, o_strobe && !o_data.last_char, (o_data.char_out == CH_MINUS) || ((o_data.char_out >= CH_ZERO) && (o_data.char_out <= CH_NINE)))
    `ICD_ASSERT_NEXT(a_minus_then_lead, i_clk, i_rst_n, o_strobe && (o_data.char_out == CH_MINUS), o_strobe && (o_data.char_out >= CH_ONE) && (o_data.char_out <= CH_NINE))
    `ICD_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_strobe && !o_data.last_char, o_strobe)

endmodule

bind int_calc_decimal_out icd_checker u_icd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_strobe(o_strobe),
    .o_data  (o_data)
);
